// ===== hdl/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and codes of the bitmap page allocator: command and result
// words, opcodes, status codes, register indexes and controller states.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int CFG_W     = 17;
  localparam int PAGE_W    = 16;
  localparam int REG_IDX_W = 2;
  localparam int STS_W     = 3;

  // pages below this index are never handed out by init
  localparam int LOW_RESERVED = 256;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_NOP   = 2'd3
  } bpa_op_t;

  localparam logic [STS_W-1:0] STS_OK        = 3'd0;
  localparam logic [STS_W-1:0] STS_NO_MEMORY = 3'd1;
  localparam logic [STS_W-1:0] STS_RANGE     = 3'd2;
  localparam logic [STS_W-1:0] STS_DOUBLE    = 3'd3;
  localparam logic [STS_W-1:0] STS_NO_CONFIG = 3'd4;

  localparam logic [REG_IDX_W-1:0] REG_PAGE_COUNT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_BASE_PAGE  = 2'd1;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [PAGE_W-1:0] page_index;
  } alloc_cmd_t;

  typedef struct packed {
    logic [STS_W-1:0]  status;
    logic [PAGE_W-1:0] alloc_page;
    logic [CFG_W-1:0]  free_pages;
  } alloc_rsp_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_REPLY,
    S_INIT_LO,
    S_INIT_HI,
    S_SWEEP,
    S_SCAN,
    S_PICK,
    S_FREE_SPLIT,
    S_FREE_CHK
  } bpa_state_t;

endpackage

// ===== hdl/bpa_ram.sv =====
// ----------------------------------------------------------------------------
// bpa_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/bpa_split.sv =====
// ----------------------------------------------------------------------------
// bpa_split
// Splits a page number into map entry index and bit position: a two stage
// divide by a constant through a reciprocal multiply, then the remainder.
// ----------------------------------------------------------------------------
module bpa_split #(
  parameter int XW      = 17,
  parameter int DIVISOR = 64,
  parameter int RW      = $clog2(DIVISOR)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [XW-1:0] x,
  output logic          out_valid,
  output logic [XW-1:0] q,
  output logic [RW-1:0] r
);

  // shift wide enough that the rounded-up reciprocal gives exact quotients
  localparam int SH = XW + RW;
  localparam int MW = XW + 2;
  localparam int PW = XW + MW;
  localparam logic [63:0] RECIP_L = ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [MW-1:0] RECIP = MW'(RECIP_L);
  localparam logic [XW-1:0] DIV_X = XW'(DIVISOR);

  logic          v1;
  logic [XW-1:0] x1;
  logic [XW-1:0] q1;
  logic [PW-1:0] prod;
  logic [XW-1:0] qd;
  logic [XW-1:0] rem;

  assign prod = PW'(x) * PW'(RECIP);
  assign qd   = q1 * DIV_X;
  assign rem  = x1 - qd;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    x1 <= x;
    q1 <= XW'(prod >> SH);
    q  <= q1;
    r  <= RW'(rem);
  end

endmodule

// ===== hdl/bitmap_page_allocator_top.sv =====
// ----------------------------------------------------------------------------
// bitmap_page_allocator_top
// First-fit page frame allocator keeping one used bit per page in a RAM.
// ----------------------------------------------------------------------------
// usage
//   command channel: a command word (opcode, page_index) is taken on a clock
//   edge with start high and busy low; busy stays high until the result word
//   goes out. results: done pulses for one cycle with the result word on rsp;
//   the receiver cannot stall, so it must take the word in that cycle.
//   config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; ready is
//   always high, registers should only be written while busy is low.
//   path of a command from the edge of start to done:
//     nop, no config and out of range replies go straight to the reply state
//     free splits the page, reads its entry, clears the bit if set
//     alloc scans from the cursor, then takes the first clear bit found
//     init splits both bounds, then the sweep writes one entry per cycle
//   a search cursor remembers the lowest entry that may hold a free page, so
//   alloc normally reads one entry; one item is in flight at a time and the
//   single RAM port pair sets the pace of the scan and the sweep.
//   reset: the map is filled with all ones by a clearing pass, with busy
//   high throughout; config writes are still taken meanwhile.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_top #(
  parameter int MAX_PAGES = 65536,
  parameter int WORD_BITS = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  bpa_pkg::alloc_cmd_t              cmd,
  output logic                             done,
  output bpa_pkg::alloc_rsp_t              rsp,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bpa_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [bpa_pkg::CFG_W-1:0]        cfg_data
);

  import bpa_pkg::*;

  localparam int WB        = WORD_BITS;
  localparam int MAP_WORDS = (MAX_PAGES + WB - 1) / WB;
  localparam int WI        = $clog2(MAP_WORDS);
  localparam int PW        = WI + 1;
  localparam int BW        = $clog2(WB);
  localparam int CW        = $clog2(MAX_PAGES + 1);
  localparam int NW        = (CW > CFG_W) ? CW : CFG_W;

  localparam logic [WB-1:0] ALL_W    = '1;
  localparam logic [WB-1:0] ONE_W    = WB'(1);
  localparam logic [PW-1:0] END_PTR  = PW'(MAP_WORDS);
  localparam logic [PW-1:0] LAST_PTR = PW'(MAP_WORDS - 1);
  localparam logic [NW-1:0] MAX_N    = NW'(MAX_PAGES);
  localparam logic [NW-1:0] WB_N     = NW'(WB);
  localparam logic [NW-1:0] LOW_N    = NW'(LOW_RESERVED);
  localparam logic [NW-1:0] WORDS_N  = NW'(MAP_WORDS);
  localparam logic [CW-1:0] MAX_C    = CW'(MAX_PAGES);

  // lowest clear bit of a map entry that is known not to be all ones
  function automatic logic [BW-1:0] first_zero(input logic [WB-1:0] w);
    logic [BW-1:0] b;
    b = '0;
    for (int i = WB - 1; i >= 0; i--) begin
      if (!w[i]) begin
        b = BW'(i);
      end
    end
    return b;
  endfunction

  // free count as it appears in the result word
  function automatic logic [CFG_W-1:0] count_field(input logic [CW-1:0] c);
    logic [NW-1:0] w;
    w = NW'(c);
    return w[CFG_W-1:0];
  endfunction

  // configuration registers
  logic [CFG_W-1:0] page_count;
  logic [CFG_W-1:0] base_page;

  // controller state
  bpa_state_t state, state_next;
  logic [PW-1:0] ptr, ptr_next;
  logic [PW-1:0] scan_from, scan_from_next;   // every entry below is all ones
  logic          rd_pend, rd_pend_next;
  logic [WI-1:0] rd_addr, rd_addr_next;
  logic [CW-1:0] cnt, cnt_next;
  logic          done_next;

  // per-command working registers
  logic [WB-1:0]    hit_word, hit_word_next;
  logic [WI-1:0]    hit_addr, hit_addr_next;
  logic [BW-1:0]    hit_bit, hit_bit_next;
  logic [NW-1:0]    sw, sw_next;              // entry holding the first free page
  logic [NW-1:0]    tw, tw_next;              // entry holding the page total
  logic [WB-1:0]    ge_part, ge_part_next;
  logic [WB-1:0]    lt_part, lt_part_next;
  logic [NW-1:0]    start_pg, start_pg_next;
  logic [NW-1:0]    tot, tot_next;
  logic [STS_W-1:0] rep_status, rep_status_next;
  alloc_rsp_t       rsp_next;

  // map RAM
  logic          ram_we;
  logic [WI-1:0] ram_waddr;
  logic [WB-1:0] ram_wdata;
  logic          ram_re;
  logic [WI-1:0] ram_raddr;
  logic [WB-1:0] ram_rdata;

  // page splitter
  logic          sp_in_valid;
  logic [NW-1:0] sp_x;
  logic          sp_out_valid;
  logic [NW-1:0] sp_q;
  logic [BW-1:0] sp_r;

  // derived values
  logic [NW-1:0] tp_n;
  logic [NW-1:0] ff_n;
  logic [NW-1:0] eff_total;
  logic [NW-1:0] start_c;
  logic [NW-1:0] ptr_n;
  logic [WB-1:0] ge_mask;
  logic [WB-1:0] lt_mask;
  logic [NW-1:0] pick_page;
  logic [CW-1:0] init_cnt;
  logic [CW-1:0] cnt_dec;
  logic [CW-1:0] cnt_inc;
  logic [PW-1:0] hit_ptr;

  bpa_ram #(
    .WIDTH (WB),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bpa_split #(
    .XW      (NW),
    .DIVISOR (WB)
  ) u_split (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sp_in_valid),
    .x         (sp_x),
    .out_valid (sp_out_valid),
    .q         (sp_q),
    .r         (sp_r)
  );

  // the page total saturates at the size of the map
  assign tp_n      = NW'(page_count);
  assign ff_n      = NW'(base_page);
  assign eff_total = (tp_n > MAX_N) ? MAX_N : tp_n;
  assign start_c   = (ff_n > LOW_N) ? ff_n : LOW_N;

  // free bits of the entry under the sweep: at or above start and below total
  assign ptr_n   = NW'(ptr);
  assign ge_mask = (ptr_n > sw) ? ALL_W : ((ptr_n == sw) ? ge_part : '0);
  assign lt_mask = (ptr_n < tw) ? ALL_W : ((ptr_n == tw) ? lt_part : '0);

  assign pick_page = NW'(hit_addr) * WB_N + NW'(hit_bit);
  assign init_cnt  = (tot > start_pg) ? CW'(tot - start_pg) : '0;
  assign cnt_dec   = (cnt != '0) ? cnt - CW'(1) : cnt;
  assign cnt_inc   = (cnt < MAX_C) ? cnt + CW'(1) : cnt;
  assign hit_ptr   = {1'b0, hit_addr};

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // config writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      page_count <= '0;
      base_page  <= CFG_W'(LOW_RESERVED);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PAGE_COUNT: page_count <= cfg_data;
        REG_BASE_PAGE:  base_page  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      ptr       <= '0;
      scan_from <= END_PTR;
      rd_pend   <= 1'b0;
      cnt       <= '0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      ptr       <= ptr_next;
      scan_from <= scan_from_next;
      rd_pend   <= rd_pend_next;
      cnt       <= cnt_next;
      done      <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr    <= rd_addr_next;
    hit_word   <= hit_word_next;
    hit_addr   <= hit_addr_next;
    hit_bit    <= hit_bit_next;
    sw         <= sw_next;
    tw         <= tw_next;
    ge_part    <= ge_part_next;
    lt_part    <= lt_part_next;
    start_pg   <= start_pg_next;
    tot        <= tot_next;
    rep_status <= rep_status_next;
    rsp        <= rsp_next;
  end

  always_comb begin
    state_next      = state;
    ptr_next        = ptr;
    scan_from_next  = scan_from;
    rd_pend_next    = rd_pend;
    rd_addr_next    = rd_addr;
    cnt_next        = cnt;
    done_next       = 1'b0;
    hit_word_next   = hit_word;
    hit_addr_next   = hit_addr;
    hit_bit_next    = hit_bit;
    sw_next         = sw;
    tw_next         = tw;
    ge_part_next    = ge_part;
    lt_part_next    = lt_part;
    start_pg_next   = start_pg;
    tot_next        = tot;
    rep_status_next = rep_status;
    rsp_next        = rsp;
    ram_we          = 1'b0;
    ram_waddr       = ptr[WI-1:0];
    ram_wdata       = ALL_W;
    ram_re          = 1'b0;
    ram_raddr       = ptr[WI-1:0];
    sp_in_valid     = 1'b0;
    sp_x            = NW'(cmd.page_index);

    unique case (state)
      // fill every entry with ones after reset
      S_CLEAR: begin
        ram_we = 1'b1;
        if (ptr == LAST_PTR) begin
          state_next = S_IDLE;
        end else begin
          ptr_next = ptr + PW'(1);
        end
      end

      S_IDLE: begin
        if (start) begin
          tot_next      = eff_total;
          start_pg_next = start_c;
          unique case (cmd.opcode)
            OP_INIT: begin
              if (eff_total == '0) begin
                rep_status_next = STS_NO_CONFIG;
                state_next      = S_REPLY;
              end else begin
                sp_in_valid = 1'b1;
                sp_x        = start_c;
                state_next  = S_INIT_LO;
              end
            end
            OP_ALLOC: begin
              ptr_next     = scan_from;
              rd_pend_next = 1'b0;
              state_next   = S_SCAN;
            end
            OP_FREE: begin
              if (NW'(cmd.page_index) >= eff_total) begin
                rep_status_next = STS_RANGE;
                state_next      = S_REPLY;
              end else begin
                sp_in_valid = 1'b1;
                state_next  = S_FREE_SPLIT;
              end
            end
            default: begin
              rep_status_next = STS_OK;
              state_next      = S_REPLY;
            end
          endcase
        end
      end

      S_REPLY: begin
        done_next           = 1'b1;
        rsp_next.status     = rep_status;
        rsp_next.alloc_page = '0;
        rsp_next.free_pages = count_field(cnt);
        state_next          = S_IDLE;
      end

      // split the first free page, then the page total
      S_INIT_LO: begin
        if (sp_out_valid) begin
          sw_next      = sp_q;
          ge_part_next = ALL_W << sp_r;
          sp_in_valid  = 1'b1;
          sp_x         = tot;
          state_next   = S_INIT_HI;
        end
      end

      S_INIT_HI: begin
        if (sp_out_valid) begin
          tw_next      = sp_q;
          lt_part_next = ~(ALL_W << sp_r);
          ptr_next     = '0;
          state_next   = S_SWEEP;
        end
      end

      S_SWEEP: begin
        ram_we    = 1'b1;
        ram_wdata = ~(ge_mask & lt_mask);
        if (ptr == LAST_PTR) begin
          cnt_next            = init_cnt;
          scan_from_next      = (sw < WORDS_N) ? PW'(sw) : END_PTR;
          done_next           = 1'b1;
          rsp_next.status     = STS_OK;
          rsp_next.alloc_page = '0;
          rsp_next.free_pages = count_field(init_cnt);
          state_next          = S_IDLE;
        end else begin
          ptr_next = ptr + PW'(1);
        end
      end

      // one entry read per cycle from the cursor until one has a clear bit or the map ends
      S_SCAN: begin
        if (rd_pend && (ram_rdata != ALL_W)) begin
          hit_word_next = ram_rdata;
          hit_addr_next = rd_addr;
          hit_bit_next  = first_zero(ram_rdata);
          state_next    = S_PICK;
        end else if (ptr == END_PTR) begin
          scan_from_next      = END_PTR;
          done_next           = 1'b1;
          rsp_next.status     = STS_NO_MEMORY;
          rsp_next.alloc_page = '0;
          rsp_next.free_pages = count_field(cnt);
          state_next          = S_IDLE;
        end else begin
          ram_re       = 1'b1;
          rd_addr_next = ptr[WI-1:0];
          rd_pend_next = 1'b1;
          ptr_next     = ptr + PW'(1);
        end
      end

      // first clear bit found, but it only counts below the page total
      S_PICK: begin
        scan_from_next      = hit_ptr;
        done_next           = 1'b1;
        rsp_next.free_pages = count_field(cnt);
        state_next          = S_IDLE;
        if (pick_page < tot) begin
          ram_we              = 1'b1;
          ram_waddr           = hit_addr;
          ram_wdata           = hit_word | (ONE_W << hit_bit);
          cnt_next            = cnt_dec;
          rsp_next.status     = STS_OK;
          rsp_next.alloc_page = pick_page[PAGE_W-1:0];
          rsp_next.free_pages = count_field(cnt_dec);
        end else begin
          rsp_next.status     = STS_NO_MEMORY;
          rsp_next.alloc_page = '0;
        end
      end

      S_FREE_SPLIT: begin
        if (sp_out_valid) begin
          ram_re        = 1'b1;
          ram_raddr     = sp_q[WI-1:0];
          hit_addr_next = sp_q[WI-1:0];
          hit_bit_next  = sp_r;
          state_next    = S_FREE_CHK;
        end
      end

      S_FREE_CHK: begin
        done_next           = 1'b1;
        rsp_next.alloc_page = '0;
        rsp_next.free_pages = count_field(cnt);
        state_next          = S_IDLE;
        if (!ram_rdata[hit_bit]) begin
          rsp_next.status = STS_DOUBLE;
        end else begin
          ram_we              = 1'b1;
          ram_waddr           = hit_addr;
          ram_wdata           = ram_rdata & ~(ONE_W << hit_bit);
          cnt_next            = cnt_inc;
          scan_from_next      = (hit_ptr < scan_from) ? hit_ptr : scan_from;
          rsp_next.status     = STS_OK;
          rsp_next.free_pages = count_field(cnt_inc);
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/bpa_checker.sv =====
// ----------------------------------------------------------------------------
// bpa_checker
// Port-level checks of the bitmap page allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bpa_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                done,
  input bpa_pkg::alloc_rsp_t rsp
);

  import bpa_pkg::*;

  // a taken command always holds the block off further commands
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("command taken without busy rising");

  // the result word closes the command
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result word while still busy");

  // one result word per command, never two in a row
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  // a page number only comes with a successful alloc
  a_page_zero: assert property (@(posedge clk) disable iff (rst)
    done && (rsp.status != STS_OK) |-> (rsp.alloc_page == '0))
    else $error("page number on a failed command");

endmodule

bind bitmap_page_allocator_top bpa_checker u_bpa_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);

// ===== dv/page_frame_scoreboard_pkg.sv =====
// ----------------------------------------------------------------------------
// page_frame_scoreboard_pkg
// Scoreboard for the bitmap page allocator: keeps its own copy of the used
// map, the free count and both registers, predicts the result word of every
// accepted command word and checks the words that come back, in order.
// ----------------------------------------------------------------------------
package page_frame_scoreboard_pkg;

  timeunit 1ns;
  timeprecision 1ps;

  import bpa_pkg::*;

  localparam int unsigned PAGE_LIMIT = 65536;
  localparam int unsigned MAP_BITS   = 64;
  localparam int unsigned MAP_WORDS  = PAGE_LIMIT / MAP_BITS;

  class page_frame_scoreboard;

    bit [MAP_BITS-1:0] used_words[MAP_WORDS];
    int unsigned       free_cnt;
    int unsigned       pages_reg;
    int unsigned       first_reg;

    alloc_rsp_t        expected_replies[$];
    int unsigned       errors;
    int unsigned       replies_checked;
    int unsigned       op_seen[4];
    int unsigned       status_seen[8];

    function new();
      foreach (used_words[i]) used_words[i] = '1;
      free_cnt  = 0;
      pages_reg = 0;
      first_reg = LOW_RESERVED;
    endfunction

    // unknown indexes are dropped, as the block does
    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == REG_PAGE_COUNT) pages_reg = data;
      else if (idx == REG_BASE_PAGE) first_reg = data;
    endfunction

    function int unsigned pending();
      return expected_replies.size();
    endfunction

    function alloc_rsp_t predict_reply(alloc_cmd_t c);
      alloc_rsp_t  r;
      int unsigned lim;
      int unsigned lo;
      int unsigned p;
      int unsigned w;
      int unsigned b;
      bit          hit;
      r = '0;
      r.status = STS_OK;
      lim = (pages_reg > PAGE_LIMIT) ? PAGE_LIMIT : pages_reg;
      case (c.opcode)
        OP_INIT: begin
          if (lim == 0) begin
            r.status = STS_NO_CONFIG;
          end else begin
            foreach (used_words[i]) used_words[i] = '1;
            free_cnt = 0;
            lo = (first_reg > LOW_RESERVED) ? first_reg : LOW_RESERVED;
            for (p = lo; p < lim; p++) begin
              used_words[p / MAP_BITS][p % MAP_BITS] = 1'b0;
              free_cnt++;
            end
          end
        end
        OP_ALLOC: begin
          // lowest free page anywhere; it only counts if it lies below the total
          r.status = STS_NO_MEMORY;
          hit = 1'b0;
          for (w = 0; w < MAP_WORDS && !hit; w++) begin
            if (used_words[w] != '1) begin
              hit = 1'b1;
              b = 0;
              while (b < MAP_BITS - 1 && used_words[w][b]) b++;
              p = w * MAP_BITS + b;
              if (p < lim) begin
                used_words[w][b] = 1'b1;
                if (free_cnt > 0) free_cnt--;
                r.status     = STS_OK;
                r.alloc_page = PAGE_W'(p);
              end
            end
          end
        end
        OP_FREE: begin
          p = c.page_index;
          if (p >= lim) begin
            r.status = STS_RANGE;
          end else if (!used_words[p / MAP_BITS][p % MAP_BITS]) begin
            r.status = STS_DOUBLE;
          end else begin
            used_words[p / MAP_BITS][p % MAP_BITS] = 1'b0;
            if (free_cnt < PAGE_LIMIT) free_cnt++;
          end
        end
        default: ;
      endcase
      r.free_pages = CFG_W'(free_cnt);
      return r;
    endfunction

    function alloc_rsp_t note_command(alloc_cmd_t c);
      alloc_rsp_t r;
      r = predict_reply(c);
      op_seen[c.opcode]++;
      status_seen[r.status]++;
      expected_replies.push_back(r);
      return r;
    endfunction

    function void report(string field, logic [CFG_W-1:0] want, logic [CFG_W-1:0] got);
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endfunction

    function void check_reply(alloc_rsp_t got);
      alloc_rsp_t want;
      if (expected_replies.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result word, expected none, got status %0d page %0d free %0d",
                 $time, got.status, got.alloc_page, got.free_pages);
        return;
      end
      want = expected_replies.pop_front();
      replies_checked++;
      if (got.status !== want.status)
        report("status", CFG_W'(want.status), CFG_W'(got.status));
      if (got.alloc_page !== want.alloc_page)
        report("alloc_page", CFG_W'(want.alloc_page), CFG_W'(got.alloc_page));
      if (got.free_pages !== want.free_pages)
        report("free_pages", want.free_pages, got.free_pages);
    endfunction

  endclass

endpackage

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for bitmap_page_allocator_top. Directed command words
// cover the empty configuration, exhaustion, range and double-free errors and
// a total lowered after init; random phases then usually reprogram both registers
// and run mostly alloc/free traffic over small maps, with random gaps.
// ----------------------------------------------------------------------------
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  import bpa_pkg::*;
  import page_frame_scoreboard_pkg::*;

  // indexes the block has no register behind
  localparam logic [REG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam int unsigned RANDOM_WORDS = 800;
  localparam int unsigned DRAIN_CYCLES = 40;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 start     = 1'b0;
  logic                 busy;
  alloc_cmd_t           cmd       = '0;
  logic                 done;
  alloc_rsp_t           rsp;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  page_frame_scoreboard sb = new();

  // pages the bench believes it holds, used to build legal frees
  logic [PAGE_W-1:0]    taken_pages[$];
  int unsigned          words_sent = 0;

  always #2 clk = ~clk;

  bitmap_page_allocator_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // result words cannot be stalled, so every strobe is taken on the edge
  // closing its cycle; the block updates on nonblocking writes, so the
  // values read here are those from before the edge
  always @(posedge clk) begin
    if (!rst && done) sb.check_reply(rsp);
  end

  // register write; valid is left high so back-to-back writes never lower
  // and raise it in one step, the caller drops it after the last write
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  // drop start and sit until every expected word is back and busy is low,
  // always waiting for a clock edge first so start cannot bounce within a step
  task automatic hold_until_drained();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0 || busy) @(posedge clk);
  endtask

  // one command word; start stays high into the next word unless a gap is drawn
  task automatic issue(bpa_op_t op, logic [PAGE_W-1:0] idx);
    alloc_cmd_t c;
    alloc_rsp_t r;
    bit         gaps_on;
    // long gap-free stretch in the middle of the random traffic
    gaps_on = !(words_sent >= 300 && words_sent < 460);
    if (gaps_on && $urandom_range(0, 99) < 7) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    c.opcode     = op;
    c.page_index = idx;
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    words_sent++;
    r = sb.note_command(c);
    if (op == OP_INIT && r.status == STS_OK) taken_pages.delete();
    if (op == OP_ALLOC && r.status == STS_OK) taken_pages.push_back(r.alloc_page);
  endtask

  task automatic directed_words();
    // out of reset: no pages configured at all
    issue(OP_ALLOC, '0);
    issue(OP_INIT, 16'hFFFF);
    issue(OP_FREE, '0);
    issue(OP_NOP, 16'hFFFF);
    hold_until_drained();

    // first free page below the reserved area is pulled up to it
    write_reg(REG_PAGE_COUNT, 17'd300);
    write_reg(REG_BASE_PAGE, 17'd0);
    cfg_valid <= 1'b0;
    issue(OP_INIT, '0);
    issue(OP_ALLOC, '0);
    issue(OP_ALLOC, '0);
    issue(OP_FREE, 16'd256);
    issue(OP_FREE, 16'd256);       // second free of the same page
    issue(OP_FREE, 16'd300);       // exactly at the total
    issue(OP_FREE, 16'hFFFF);
    issue(OP_FREE, 16'd255);       // reserved page is used, so freeing it is legal
    issue(OP_ALLOC, '0);           // now hands out the reserved page
    hold_until_drained();

    // full map with only the top page free
    write_reg(REG_PAGE_COUNT, 17'd65536);
    write_reg(REG_BASE_PAGE, 17'd65535);
    cfg_valid <= 1'b0;
    issue(OP_INIT, '0);
    issue(OP_ALLOC, '0);
    issue(OP_ALLOC, '0);           // exhausted
    issue(OP_FREE, 16'hFFFF);
    hold_until_drained();

    // saturated total, first free page beyond it: init frees nothing
    write_reg(REG_PAGE_COUNT, 17'h1FFFF);
    write_reg(REG_BASE_PAGE, 17'h1FFFF);
    cfg_valid <= 1'b0;
    issue(OP_INIT, '0);
    issue(OP_ALLOC, '0);
    hold_until_drained();

    // total lowered after init: free pages above it stay counted
    write_reg(REG_PAGE_COUNT, 17'd1000);
    write_reg(REG_BASE_PAGE, 17'd256);
    cfg_valid <= 1'b0;
    issue(OP_INIT, '0);
    hold_until_drained();
    write_reg(REG_PAGE_COUNT, 17'd260);
    cfg_valid <= 1'b0;
    issue(OP_ALLOC, '0);
    issue(OP_FREE, 16'd500);
    hold_until_drained();
    write_reg(REG_PAGE_COUNT, 17'd256);
    cfg_valid <= 1'b0;
    issue(OP_ALLOC, '0);           // lowest free page sits above the total
    issue(OP_NOP, '0);
    hold_until_drained();
  endtask

  // one phase: new settings, usually an init, then alloc/free traffic
  task automatic random_phase();
    int unsigned       pick;
    int unsigned       n_ops;
    int unsigned       span;
    int unsigned       k;
    logic [CFG_W-1:0]  total_v;
    logic [CFG_W-1:0]  first_v;
    logic [PAGE_W-1:0] pg;
    hold_until_drained();

    pick = $urandom_range(0, 99);
    if (pick < 55) total_v = CFG_W'(257 + $urandom_range(0, 300));   // small, runs dry
    else if (pick < 68) total_v = CFG_W'($urandom_range(1, 256));    // reserved pages only
    else if (pick < 73) total_v = '0;
    else if (pick < 88) total_v = CFG_W'($urandom_range(257, 65536));
    else total_v = CFG_W'($urandom);                                 // past the limit too

    pick = $urandom_range(0, 99);
    if (pick < 60) first_v = CFG_W'($urandom_range(0, 300));
    else if (pick < 85) first_v = CFG_W'($urandom_range(200, 600));
    else first_v = CFG_W'($urandom);

    // now and then a register is left alone, so the old value carries over
    if ($urandom_range(0, 9) != 0) write_reg(REG_PAGE_COUNT, total_v);
    if ($urandom_range(0, 9) != 0) write_reg(REG_BASE_PAGE, first_v);
    if ($urandom_range(0, 5) == 0)
      write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_B : REG_SPARE_A, CFG_W'($urandom));
    cfg_valid <= 1'b0;

    if ($urandom_range(0, 99) < 85) issue(OP_INIT, PAGE_W'($urandom));

    span  = (sb.pages_reg > 65527) ? 65535 : sb.pages_reg + 8;
    n_ops = $urandom_range(12, 40);
    repeat (n_ops) begin
      // occasional full drain in the middle of the traffic
      if ($urandom_range(0, 99) < 3) hold_until_drained();
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        issue(OP_ALLOC, PAGE_W'($urandom));
      end else if (pick < 78 && taken_pages.size() > 0) begin
        k  = $urandom_range(0, taken_pages.size() - 1);
        pg = taken_pages[k];
        taken_pages.delete(k);
        issue(OP_FREE, pg);
      end else if (pick < 90) begin
        // near the managed range: doubles and range errors
        issue(OP_FREE, PAGE_W'($urandom_range(0, span)));
      end else if (pick < 94) begin
        issue(OP_FREE, PAGE_W'($urandom));
      end else if (pick < 98) begin
        issue(OP_NOP, PAGE_W'($urandom));
      end else begin
        issue(OP_INIT, PAGE_W'($urandom));
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    directed_words();
    while (words_sent < RANDOM_WORDS) random_phase();

    hold_until_drained();
    // watch a little longer for stray result words
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d command words: %0d init, %0d alloc, %0d free, %0d nop",
             words_sent, sb.op_seen[OP_INIT], sb.op_seen[OP_ALLOC], sb.op_seen[OP_FREE],
             sb.op_seen[OP_NOP]);
    $display("%0d result words: %0d ok, %0d no memory, %0d range, %0d double, %0d no config",
             sb.replies_checked, sb.status_seen[STS_OK], sb.status_seen[STS_NO_MEMORY],
             sb.status_seen[STS_RANGE], sb.status_seen[STS_DOUBLE],
             sb.status_seen[STS_NO_CONFIG]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run including the clearing pass
  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/bpa_pkg.sv
hdl/bpa_ram.sv
hdl/bpa_split.sv
hdl/bitmap_page_allocator_top.sv
hdl/bpa_checker.sv
dv/page_frame_scoreboard_pkg.sv
dv/tb.sv
